[rtl/lru_key_value_cache_core_macros.svh]
// Assertion macros shared by the LRU key-value cache RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lkvc_pkg.sv]
// Shared constants and controller/datapath interface types for the LRU cache.
// No dependencies; used by lkvc_ctrl, lkvc_dpath and the top level.
package lkvc_pkg;

  localparam int CAPACITY_DEF = 16;   // default number of entry slots
  localparam int CAP_W        = 5;    // capacity_in_use register width
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;  // -1

  // Request kinds carried on the input tuser bit
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // latch an accepted request, clear scan trackers
    logic rd_issue;  // read the entry memories at the scan index
    logic commit;    // apply the update and post the result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index is at the last slot
    logic commit_ok;  // result register can take this transaction's result
  } sts_t;

endpackage

[rtl/lkvc_ctrl.sv]
// Sequencing state machine for the LRU cache: accept, scan, commit.
// Depends on lkvc_pkg for the command and status structs.
module lkvc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lkvc_pkg::sts_t  sts,
  output lkvc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_LAST   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.scan_last) state_next = ST_LAST;
      end
      // last read is compared here
      ST_LAST: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.commit_ok) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/lkvc_dpath.sv]
// Datapath of the LRU cache: key/value memories, per-slot valid and recency
// cells, scan trackers, capacity register and result register. Uses lkvc_pkg.
`include "lru_key_value_cache_core_macros.svh"

module lkvc_dpath #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                        in_func,
  input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
  input  logic [lkvc_pkg::VAL_W-1:0]  in_value,
  input  lkvc_pkg::cmd_t              cmd,
  output lkvc_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [lkvc_pkg::VAL_W-1:0]  out_value
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index
  localparam int RW = IW;                                     // recency rank
  localparam int LW = $clog2(CAPACITY + 1);                   // live count
  localparam int CW = (LW > lkvc_pkg::CAP_W) ? LW : lkvc_pkg::CAP_W;

  // Configuration
  logic [lkvc_pkg::CAP_W-1:0] cap;
  logic [lkvc_pkg::CAP_W-1:0] eff_cap;

  // Request latched at accept
  logic                       func_q;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;

  // Entry storage
  logic [lkvc_pkg::KEY_W-1:0] mem_key [CAPACITY];
  logic [lkvc_pkg::VAL_W-1:0] mem_val [CAPACITY];
  logic [lkvc_pkg::KEY_W-1:0] rd_key;
  logic [lkvc_pkg::VAL_W-1:0] rd_val;
  logic [CAPACITY-1:0]        valid;
  logic [RW-1:0]              rank [CAPACITY];
  logic [LW-1:0]              live_count;

  // Scan
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_d;
  logic          rd_pend;
  logic          cur_valid;
  logic [RW-1:0] cur_rank;
  logic          cur_lru;

  // Trackers
  logic                       hit_f;
  logic [IW-1:0]              hit_idx;
  logic [RW-1:0]              hit_rank;
  logic [lkvc_pkg::VAL_W-1:0] hit_val;
  logic                       free_f;
  logic [IW-1:0]              free_idx;
  logic                       lru_f;
  logic [IW-1:0]              lru_idx;

  // Commit decode
  logic          evict;
  logic          do_insert;
  logic          do_rank_upd;
  logic          mem_we;
  logic [IW-1:0] slot;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  assign eff_cap = (cap == '0) ? lkvc_pkg::CAP_W'(1) : cap;
  assign evict   = (CW'(live_count) >= CW'(eff_cap)) || (live_count >= LW'(CAPACITY));

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      key_q  <= in_key;
      val_q  <= in_value;
    end
  end

  // Scan index and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.rd_issue) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= idx;
  end

  // Key and value memories: one read, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_key <= mem_key[idx];
      rd_val <= mem_val[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[slot] <= key_q;
      mem_val[slot] <= val_q;
    end
  end

  // Per-slot state of the entry read last cycle
  assign cur_valid = valid[idx_d];
  assign cur_rank  = rank[idx_d];
  assign cur_lru   = cur_valid && (LW'(cur_rank) == (live_count - LW'(1)));

  // Scan trackers: hit, first free slot, least recent slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      lru_f  <= 1'b0;
    end else if (cmd.load) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
      lru_f  <= 1'b0;
    end else if (rd_pend) begin
      if (cur_valid && (rd_key == key_q) && !hit_f) begin
        hit_f    <= 1'b1;
        hit_idx  <= idx_d;
        hit_rank <= cur_rank;
        hit_val  <= rd_val;
      end
      if (!cur_valid && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= idx_d;
      end
      if (cur_lru && !lru_f) begin
        lru_f   <= 1'b1;
        lru_idx <= idx_d;
      end
    end
  end

  // Commit decode
  assign do_insert   = cmd.commit && (func_q == lkvc_pkg::FUNC_PUT) && !hit_f;
  assign do_rank_upd = cmd.commit && (hit_f || (func_q == lkvc_pkg::FUNC_PUT));
  assign mem_we      = cmd.commit && (func_q == lkvc_pkg::FUNC_PUT);

  always_comb begin
    priority if (hit_f) begin
      slot = hit_idx;
    end else if (evict) begin
      slot = lru_idx;
    end else begin
      slot = free_idx;
    end
  end

  // Valid and recency cells: touch ages entries newer than the hit,
  // insert ages every other valid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < CAPACITY; i++) rank[i] <= '0;
    end else if (do_rank_upd) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IW'(i) == slot) begin
          rank[i] <= '0;
          if (do_insert) valid[i] <= 1'b1;
        end else if (valid[i] && (!hit_f || (rank[i] < hit_rank))) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end
  end

  // Live count grows only on an insert into a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (do_insert && !evict) begin
      live_count <= live_count + LW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && (func_q == lkvc_pkg::FUNC_GET)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (func_q == lkvc_pkg::FUNC_GET)) begin
      out_found <= hit_f;
      out_value <= hit_f ? hit_val : lkvc_pkg::MISS_VALUE;
    end
  end

  // Status
  assign sts.scan_last = (idx == IW'(CAPACITY - 1));
  assign sts.commit_ok = (func_q == lkvc_pkg::FUNC_PUT) || !out_valid || out_ready;

  // Checks
  `LKVC_ASSERT_NOW(a_live_matches_valid, clk, rst, 1'b1, $countones(valid) == int'(live_count), "live count differs from valid entries")
  `LKVC_ASSERT_NOW(a_free_slot_found, clk, rst, do_insert && !evict, free_f, "insert below capacity without a free slot")
  `LKVC_ASSERT_NOW(a_lru_slot_found, clk, rst, do_insert && evict, lru_f, "eviction without a least recent entry")
  `LKVC_ASSERT_NEXT(a_live_grows, clk, rst, do_insert && !evict, live_count == $past(live_count) + LW'(1), "live count did not grow on insert")

endmodule

[rtl/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache: streaming ports, capacity register port.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dpath.
//
//  Channel  Dir  Transaction content
//  s_axis   in   tuser: func; tdata: lookup_key, store_value
//  m_axis   out  tuser: found; tdata: read_value (one per get)
//  cfg      in   capacity_in_use, written when cfg_wr_en is high
//
// Each request scans the key/value memory one slot per cycle through its
// single read port. Results sit in an output register, so the next request
// is accepted while a result waits; a get only holds in its commit cycle
// while that register is full and not taken. Reset clears valid bits,
// recency ranks and the live count at once and sets the capacity to 16;
// no clearing pass is needed.
module lru_key_value_cache_core #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,    // capacity_in_use
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,   // [31:0] lookup_key, [63:32] store_value
  input  logic [0:0]                 s_axis_tuser,   // [0] func
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [31:0] read_value
  output logic [0:0]                 m_axis_tuser    // [0] found
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkvc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_func     (s_axis_tuser[0]),
    .in_key      (s_axis_tdata[31:0]),
    .in_value    (s_axis_tdata[63:32]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_found   (m_axis_tuser[0]),
    .out_value   (m_axis_tdata)
  );

endmodule

[tb/lru_key_value_cache_core_tb.sv]
// Testbench for lru_key_value_cache_core: directed and random get/put traffic
// checked against a behavioral LRU cache model. Depends on lkvc_pkg and the RTL.
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;

  localparam int SLOTS   = lkvc_pkg::CAPACITY_DEF;
  localparam int SETTLE  = 2 * (SLOTS + 3) + 4;   // cycles for an in-flight put to finish
  localparam int N_PHASE = 8;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic                       found;
    logic [lkvc_pkg::VAL_W-1:0] value;
  } read_result_t;

  // DUT ports
  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [63:0]                s_axis_tdata;   // [31:0] lookup_key, [63:32] store_value
  logic [0:0]                 s_axis_tuser;   // [0] func
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [31:0]                m_axis_tdata;   // [31:0] read_value
  logic [0:0]                 m_axis_tuser;   // [0] found

  // Cache model state
  logic [lkvc_pkg::KEY_W-1:0] mdl_key   [SLOTS];
  logic [lkvc_pkg::VAL_W-1:0] mdl_val   [SLOTS];
  bit                         mdl_valid [SLOTS];
  int                         mdl_rank  [SLOTS];
  int                         mdl_live;
  logic [lkvc_pkg::CAP_W-1:0] mdl_cap;

  read_result_t pending_reads[$];

  // Run bookkeeping
  int  errors      = 0;
  int  n_requests  = 0;
  int  n_gets      = 0;
  int  n_hits      = 0;
  int  n_evictions = 0;
  int  n_cfg       = 0;
  int  n_checked   = 0;
  bit  burst_mode  = 1'b0;
  bit  rx_hold     = 1'b0;
  int  rx_gap      = 0;
  event hold_off_ev;

  lru_key_value_cache_core #(.CAPACITY(SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly zero or short, now and then long
  function automatic int idle_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------- cache model ----------------
  function automatic int cap_limit();
    int c;
    c = int'(mdl_cap);
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic void cache_clear();
    for (int i = 0; i < SLOTS; i++) begin
      mdl_key[i]   = '0;
      mdl_val[i]   = '0;
      mdl_valid[i] = 1'b0;
      mdl_rank[i]  = 0;
    end
    mdl_live = 0;
    mdl_cap  = lkvc_pkg::CAP_RESET;
  endfunction

  function automatic int find_slot(input logic [lkvc_pkg::KEY_W-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (mdl_valid[i] && mdl_key[i] == key) return i;
    return -1;
  endfunction

  // Move slot to most recent; entries younger than it age by one
  function automatic void promote(input int s);
    int r;
    r = mdl_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (mdl_valid[i] && i != s && mdl_rank[i] < r) mdl_rank[i]++;
    mdl_rank[s] = 0;
  endfunction

  // Apply one request; returns 1 when it produces a read result
  function automatic bit cache_apply(input logic func,
                                     input logic [lkvc_pkg::KEY_W-1:0] key,
                                     input logic [lkvc_pkg::VAL_W-1:0] val,
                                     output read_result_t res);
    int  hit;
    int  slot;
    int  worst;
    bit  any;
    bit  placed;
    hit = find_slot(key);
    res = '0;
    if (func == lkvc_pkg::FUNC_GET) begin
      if (hit < 0) begin
        res.found = 1'b0;
        res.value = lkvc_pkg::MISS_VALUE;
      end else begin
        promote(hit);
        res.found = 1'b1;
        res.value = mdl_val[hit];
      end
      return 1'b1;
    end
    if (hit >= 0) begin
      mdl_val[hit] = val;
      promote(hit);
      return 1'b0;
    end
    // Insert: evict least recent when full (also when capacity was lowered)
    slot = 0;
    if (mdl_live >= cap_limit()) begin
      any   = 1'b0;
      worst = 0;
      for (int i = 0; i < SLOTS; i++)
        if (mdl_valid[i] && (!any || mdl_rank[i] > worst)) begin
          worst = mdl_rank[i];
          slot  = i;
          any   = 1'b1;
        end
      if (any) begin
        mdl_valid[slot] = 1'b0;
        n_evictions++;
      end else begin
        mdl_live = 0;
      end
    end
    if (!(mdl_live >= cap_limit())) begin
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++)
        if (!placed && !mdl_valid[i]) begin
          slot   = i;
          placed = 1'b1;
        end
      mdl_live++;
    end
    for (int i = 0; i < SLOTS; i++)
      if (mdl_valid[i]) mdl_rank[i]++;
    mdl_key[slot]   = key;
    mdl_val[slot]   = val;
    mdl_valid[slot] = 1'b1;
    mdl_rank[slot]  = 0;
    return 1'b0;
  endfunction

  // ---------------- drivers ----------------
  // Offer one request on s_axis; called and returns at a falling edge
  task automatic send_request(input logic func, input logic [lkvc_pkg::KEY_W-1:0] key,
                              input logic [lkvc_pkg::VAL_W-1:0] val);
    int           gap;
    read_result_t res;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {val, key};
    do @(posedge clk); while (!s_axis_tready);
    // transaction accepted at this edge
    n_requests++;
    if (cache_apply(func, key, val, res)) begin
      n_gets++;
      if (res.found) n_hits++;
      pending_reads.push_back(res);
    end
    @(negedge clk);
  endtask

  // Stop offering and wait until every read result is back and the core is quiet
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [lkvc_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    mdl_cap     = cap;
    n_cfg++;
  endtask

  // Long receiver hold-off, counted here once requested
  always begin
    @(hold_off_ev);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Receiver: random back-pressure plus the long hold-off
  always @(negedge clk) begin
    if (rx_hold) begin
      m_axis_tready = 1'b0;
    end else if (rx_gap > 0) begin
      m_axis_tready = 1'b0;
      rx_gap--;
    end else begin
      m_axis_tready = 1'b1;
      rx_gap = idle_len();
    end
  end

  // Result checker: each m_axis transaction against the oldest expected read
  always @(posedge clk) begin
    read_result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: found=%0b read_value=%08h", m_axis_tuser[0], m_axis_tdata);
        errors++;
      end else begin
        exp_res = pending_reads.pop_front();
        n_checked++;
        if (m_axis_tuser[0] !== exp_res.found) begin
          $error("found mismatch: expected %0b actual %0b", exp_res.found, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata !== exp_res.value) begin
          $error("read_value mismatch: expected %08h actual %08h", exp_res.value,
                 m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  // Lookups in an empty cache miss
  task automatic test_empty_lookup();
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
  endtask

  // Extreme keys and values, a stored -1 against a miss, value update
  task automatic test_extremes_update();
    send_request(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0);
    send_request(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0);
  endtask

  // Capacity lowered below the live count: entries stay, inserts evict one each,
  // and a refreshed entry survives over the least recent one
  task automatic test_shrink_lru();
    cfg_write(5'd2);
    send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0BAD_F00D, 32'hCAFE_0001);
    send_request(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0);
  endtask

  // Capacity zero behaves as one
  task automatic test_capacity_zero();
    cfg_write(5'd0);
    send_request(lkvc_pkg::FUNC_PUT, 32'h5555_AAAA, 32'hA5A5_5A5A);
    send_request(lkvc_pkg::FUNC_GET, 32'h5555_AAAA, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h0BAD_F00D, 32'h0);
  endtask

  // Capacity above the slot count saturates
  task automatic test_capacity_saturate();
    cfg_write(5'd31);
    send_request(lkvc_pkg::FUNC_PUT, 32'hAAAA_5555, 32'h0F0F_F0F0);
    send_request(lkvc_pkg::FUNC_PUT, 32'h1357_9BDF, 32'hF0F0_0F0F);
    send_request(lkvc_pkg::FUNC_GET, 32'hAAAA_5555, 32'h0);
    send_request(lkvc_pkg::FUNC_GET, 32'h5555_AAAA, 32'h0);
  endtask

  // Random traffic over a key pool sized around the capacity
  task automatic test_random_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int n_items,
                                   input bit no_idle);
    logic [lkvc_pkg::KEY_W-1:0] pool[$];
    logic [lkvc_pkg::KEY_W-1:0] key;
    logic                       func;
    int                         pool_size;
    int                         r;
    cfg_write(cap);
    burst_mode = no_idle;
    pool_size  = cap_limit() + $urandom_range(6, 1);
    for (int i = 0; i < pool_size; i++) begin
      r = $urandom_range(9, 0);
      if (r == 0)      pool.push_back(32'h8000_0000);
      else if (r == 1) pool.push_back(32'h7FFF_FFFF);
      else             pool.push_back($urandom());
    end
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(9, 0) < 8) key = pool[$urandom_range(pool_size - 1, 0)];
      else                          key = $urandom();
      func = ($urandom_range(99, 0) < 55) ? lkvc_pkg::FUNC_GET : lkvc_pkg::FUNC_PUT;
      send_request(func, key, $urandom());
    end
    burst_mode = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the core stalls its input
  task automatic test_output_stall();
    cfg_write(5'd4);
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00A1, $urandom());
    send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00A2, $urandom());
    -> hold_off_ev;
    burst_mode = 1'b1;
    for (int n = 0; n < 12; n++)
      send_request(lkvc_pkg::FUNC_GET, (n % 3 == 2) ? $urandom() : 32'h0000_00A1 + (n % 2),
                   32'h0);
    burst_mode = 1'b0;
  endtask

  // ---------------- main sequence ----------------
  initial begin
    logic [lkvc_pkg::CAP_W-1:0] phase_cap[N_PHASE];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lkvc_pkg::FUNC_GET;
    cache_clear();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_empty_lookup();
    test_extremes_update();
    test_shrink_lru();
    test_capacity_zero();
    test_capacity_saturate();

    phase_cap = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'($urandom_range(31, 0)), 5'd3};
    for (int p = 0; p < N_PHASE; p++)
      test_random_phase(phase_cap[p], 52, (p == 2) || (p == 5));
    test_output_stall();

    wait_idle();
    $display("Ran %0d requests (%0d gets, %0d hits, %0d evictions), %0d results checked,",
             n_requests, n_gets, n_hits, n_evictions, n_checked);
    $display("across %0d capacity writes including zero, one, full and saturated.", n_cfg);
    if (errors == 0) begin
      $display("lru_key_value_cache_core_tb OK");
    end else begin
      $display("lru_key_value_cache_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("lru_key_value_cache_core_tb NOT OK");
    $finish;
  end

endmodule

[lru_key_value_cache_core.f]
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache_core.sv
tb/lru_key_value_cache_core_tb.sv
